// ===== hw/rtl/ommb_pkg.sv =====
package ommb_pkg;

	// command word from controller to datapath
	localparam int OP_W  = 5;
	localparam int IDX_W = 6;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	// datapath operations
	localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
	localparam logic [OP_W-1:0] OP_UPD_MUL = 5'd2;
	localparam logic [OP_W-1:0] OP_UPD_WB  = 5'd3;
	localparam logic [OP_W-1:0] OP_RLD     = 5'd4;
	localparam logic [OP_W-1:0] OP_RSTEP   = 5'd5;
	localparam logic [OP_W-1:0] OP_RFIN    = 5'd6;
	localparam logic [OP_W-1:0] OP_TQ      = 5'd7;
	localparam logic [OP_W-1:0] OP_TREC    = 5'd8;
	localparam logic [OP_W-1:0] OP_TEST    = 5'd9;
	localparam logic [OP_W-1:0] OP_TCOR    = 5'd10;
	localparam logic [OP_W-1:0] OP_TSQ     = 5'd11;
	localparam logic [OP_W-1:0] OP_TSQW    = 5'd12;
	localparam logic [OP_W-1:0] OP_HMUL    = 5'd13;
	localparam logic [OP_W-1:0] OP_HWB     = 5'd14;
	localparam logic [OP_W-1:0] OP_SMUL    = 5'd15;
	localparam logic [OP_W-1:0] OP_SWB     = 5'd16;
	localparam logic [OP_W-1:0] OP_MMUL    = 5'd17;
	localparam logic [OP_W-1:0] OP_MWB     = 5'd18;
	localparam logic [OP_W-1:0] OP_PUT     = 5'd19;

	// transaction function codes
	localparam logic [2:0] F_SET_POS   = 3'd0;
	localparam logic [2:0] F_SET_ANG   = 3'd1;
	localparam logic [2:0] F_SET_SCL   = 3'd2;
	localparam logic [2:0] F_TRANSLATE = 3'd3;
	localparam logic [2:0] F_ADD_ANG   = 3'd4;
	localparam logic [2:0] F_MUL_SCL   = 3'd5;

	// angle constants in q16.16 degrees
	localparam logic [24:0] DEG90  = 25'd5898240;
	localparam logic [24:0] DEG180 = 25'd11796480;
	localparam logic [24:0] DEG270 = 25'd17694720;
	localparam logic [24:0] DEG360 = 25'd23592960;

	// floor(2^37 / 45), reciprocal for the divide by 90
	localparam logic [31:0] RECIP45 = 32'd3054198966;

	// sine polynomial coefficients, q30
	localparam logic signed [32:0] SIN_C1 = 33'sd1686629713;
	localparam logic signed [32:0] SIN_C3 = -33'sd693598668;
	localparam logic signed [32:0] SIN_C5 = 33'sd85569305;
	localparam logic signed [32:0] SIN_C7 = -33'sd5026995;
	localparam logic signed [32:0] SIN_C9 = 33'sd172273;

endpackage

// ===== hw/rtl/object_model_matrix_builder.sv =====
// Object model matrix builder.
// Input channel (in_valid/in_ready): one transaction carries func and the
// operand vector vec_x/vec_y/vec_z in Q16.16. It updates the stored position,
// Euler angles or scale, then the block builds M = S*Rx*Ry*Rz*T.
// Output channel (out_valid/out_ready): one transaction per input with the
// top three rows of M, Q16.16 saturated; the bottom row is always 0 0 0 1.
// The work runs on one shared 33x33 multiplier with a registered product, in
// this order: state update, then per axis reduction and sine/cosine (7-step
// mod-360 reduction, reciprocal divide, Horner polynomial), then the rotation
// and matrix products, then the load of the output register.
// A new transaction is not accepted until the last one has left the
// sequencer; in_ready is high only while the sequencer is idle.
// Reset: position and angles clear to zero, scale to 1.0 on each axis,
// out_valid low.
// Stall: a result waits in the output register while out_ready is low; the
// next transaction is accepted and computed meanwhile, and its result waits
// in the put state until the output register is free.
module object_model_matrix_builder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] m_r0_c0,
	output logic signed [31:0] m_r0_c1,
	output logic signed [31:0] m_r0_c2,
	output logic signed [31:0] m_r0_c3,
	output logic signed [31:0] m_r1_c0,
	output logic signed [31:0] m_r1_c1,
	output logic signed [31:0] m_r1_c2,
	output logic signed [31:0] m_r1_c3,
	output logic signed [31:0] m_r2_c0,
	output logic signed [31:0] m_r2_c1,
	output logic signed [31:0] m_r2_c2,
	output logic signed [31:0] m_r2_c3
);
	import ommb_pkg::*;

	cmd_t cmd;

	// sequencer
	ommb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// arithmetic and state
	ommb_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.func    (func),
		.vec_x   (vec_x),
		.vec_y   (vec_y),
		.vec_z   (vec_z),
		.m_r0_c0 (m_r0_c0),
		.m_r0_c1 (m_r0_c1),
		.m_r0_c2 (m_r0_c2),
		.m_r0_c3 (m_r0_c3),
		.m_r1_c0 (m_r1_c0),
		.m_r1_c1 (m_r1_c1),
		.m_r1_c2 (m_r1_c2),
		.m_r1_c3 (m_r1_c3),
		.m_r2_c0 (m_r2_c0),
		.m_r2_c1 (m_r2_c1),
		.m_r2_c2 (m_r2_c2),
		.m_r2_c3 (m_r2_c3)
	);

endmodule

// ===== hw/rtl/ommb_ctrl.sv =====
module ommb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output ommb_pkg::cmd_t cmd
);
	import ommb_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD  = 3'd1;
	localparam logic [2:0] S_TRIG = 3'd2;
	localparam logic [2:0] S_MAT  = 3'd3;
	localparam logic [2:0] S_PUT  = 3'd4;

	localparam logic [6:0] UPD_LAST  = 7'd5;
	localparam logic [6:0] TRIG_LAST = 7'd40;
	localparam logic [6:0] MAT_LAST  = 7'd75;

	logic [2:0] state_q;
	logic [6:0] step_q;
	logic [1:0] axis_q;
	logic       out_valid_q;
	logic       put_ok;
	logic [4:0] tl;
	logic [3:0] tu;
	logic [3:0] hu;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign put_ok    = !out_valid_q || out_ready;

	// trig sub-sequence decode
	assign tl = 5'(step_q - 7'd9);
	assign tu = tl[3:0];
	assign hu = 4'(tu - 4'd6);

	// command generation
	always_comb begin
		cmd.op  = OP_NOP;
		cmd.idx = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_UPD: begin
				cmd.op  = step_q[0] ? OP_UPD_WB : OP_UPD_MUL;
				cmd.idx = 6'(step_q[2:1]);
			end
			S_TRIG: begin
				if (step_q == 7'd0) begin
					cmd.op  = OP_RLD;
					cmd.idx = 6'(axis_q);
				end else if (step_q <= 7'd7) begin
					cmd.op  = OP_RSTEP;
					cmd.idx = 6'(7'd7 - step_q);
				end else if (step_q == 7'd8) begin
					cmd.op  = OP_RFIN;
					cmd.idx = 6'(axis_q);
				end else begin
					case (tu)
						4'd0: begin
							cmd.op  = OP_TQ;
							cmd.idx = 6'(tl[4]);
						end
						4'd1: cmd.op = OP_TREC;
						4'd2: cmd.op = OP_TEST;
						4'd3: cmd.op = OP_TCOR;
						4'd4: cmd.op = OP_TSQ;
						4'd5: cmd.op = OP_TSQW;
						4'd14: cmd.op = OP_SMUL;
						4'd15: begin
							cmd.op  = OP_SWB;
							cmd.idx = 6'({axis_q, tl[4]});
						end
						default: begin
							cmd.op  = tu[0] ? OP_HWB : OP_HMUL;
							cmd.idx = 6'(hu[2:1]);
						end
					endcase
				end
			end
			S_MAT: begin
				cmd.op  = step_q[0] ? OP_MWB : OP_MMUL;
				cmd.idx = step_q[6:1];
			end
			S_PUT: begin
				if (put_ok) cmd.op = OP_PUT;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			axis_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_UPD;
						step_q  <= '0;
					end
				end
				S_UPD: begin
					if (step_q == UPD_LAST) begin
						state_q <= S_TRIG;
						step_q  <= '0;
						axis_q  <= '0;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				S_TRIG: begin
					if (step_q == TRIG_LAST) begin
						step_q <= '0;
						if (axis_q == 2'd2) state_q <= S_MAT;
						else axis_q <= axis_q + 2'd1;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				S_MAT: begin
					if (step_q == MAT_LAST) state_q <= S_PUT;
					else step_q <= step_q + 7'd1;
				end
				S_PUT: begin
					if (put_ok) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_PUT && put_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_UPD && step_q == 7'd0))
		else $error("accepted transaction did not start the update phase");

	a_valid_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_PUT)
		else $error("result valid raised outside the put state");

	a_trig_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TRIG) |-> (step_q <= TRIG_LAST && axis_q != 2'd3))
		else $error("trig sequence counter out of range");

	a_mat_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAT) |-> (step_q <= MAT_LAST))
		else $error("matrix sequence counter out of range");

endmodule

// ===== hw/rtl/ommb_dp.sv =====
module ommb_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ommb_pkg::cmd_t     cmd,
	input  logic [2:0]         func,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	output logic signed [31:0] m_r0_c0,
	output logic signed [31:0] m_r0_c1,
	output logic signed [31:0] m_r0_c2,
	output logic signed [31:0] m_r0_c3,
	output logic signed [31:0] m_r1_c0,
	output logic signed [31:0] m_r1_c1,
	output logic signed [31:0] m_r1_c2,
	output logic signed [31:0] m_r1_c3,
	output logic signed [31:0] m_r2_c0,
	output logic signed [31:0] m_r2_c1,
	output logic signed [31:0] m_r2_c2,
	output logic signed [31:0] m_r2_c3
);
	import ommb_pkg::*;

	// round to nearest at 2^-30, ties toward plus infinity
	function automatic logic signed [35:0] rnd30(input logic signed [65:0] x);
		logic signed [65:0] y;
		y = (x + 66'sd536870912) >>> 30;
		return y[35:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sd2147483647) return 32'sh7fffffff;
		else if (x < -66'sd2147483648) return 32'sh80000000;
		else return x[31:0];
	endfunction

	logic [2:0]         func_q;
	logic signed [31:0] vec_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [31:0] ang_q [3];
	logic signed [31:0] scl_q [3];
	logic [31:0]        red_q;
	logic               neg_q;
	logic [24:0]        r_q;
	logic [1:0]         q_q;
	logic [22:0]        f_q;
	logic [30:0]        t_q;
	logic signed [31:0] t2_q;
	logic signed [32:0] p_q;
	logic signed [31:0] trig_q [6];
	logic signed [31:0] sxsy_q;
	logic signed [31:0] cxsy_q;
	logic signed [32:0] rm_q [9];
	logic signed [63:0] acc_q;
	logic signed [35:0] vt_q;
	logic signed [65:0] hv_q;
	logic signed [65:0] prod_q;
	logic signed [31:0] m_q [12];
	logic signed [31:0] out_q [12];

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic [1:0]         ai;
	logic [31:0]        ang_u;
	logic [31:0]        red_step;
	logic [24:0]        rem;
	logic signed [31:0] rem_s;
	logic [25:0]        u26;
	logic [24:0]        u;
	logic [1:0]         tq;
	logic [22:0]        tf;
	logic [36:0]        t45;
	logic [36:0]        fx;
	logic [36:0]        remd;
	logic [30:0]        tc;
	logic signed [35:0] rr;
	logic signed [32:0] r33;
	logic signed [35:0] sc;
	logic signed [32:0] hc;
	logic signed [65:0] scl_rnd;
	logic [4:0]         rk;
	logic [1:0]         row;
	logic [2:0]         sub;
	logic [1:0]         col;
	logic [3:0]         rmi;
	logic signed [19:0] vh;
	logic signed [16:0] vl;

	assign ai = cmd.idx[1:0];

	// angle reduction helpers
	assign ang_u    = ang_q[ai];
	assign red_step = 32'({7'd0, DEG360} << cmd.idx[2:0]);
	assign rem      = red_q[24:0];
	assign rem_s    = $signed({7'd0, rem});

	// quadrant split, cosine is sine of angle plus 90
	assign u26 = {1'b0, r_q} + {1'b0, DEG90};
	always_comb begin
		if (cmd.idx[0]) u = (u26 >= {1'b0, DEG360}) ? 25'(u26 - {1'b0, DEG360}) : u26[24:0];
		else u = r_q;
		if (u >= DEG270) begin
			tq = 2'd3;
			tf = 23'(u - DEG270);
		end else if (u >= DEG180) begin
			tq = 2'd2;
			tf = 23'(u - DEG180);
		end else if (u >= DEG90) begin
			tq = 2'd1;
			tf = 23'(u - DEG90);
		end else begin
			tq = 2'd0;
			tf = u[22:0];
		end
	end

	// quotient correction for the divide by 90
	assign t45  = ({6'd0, t_q} << 5) + ({6'd0, t_q} << 3) + ({6'd0, t_q} << 2) + {6'd0, t_q};
	assign fx   = {1'b0, f_q, 13'd0};
	assign remd = fx - t45;
	assign tc   = t_q + 31'(remd >= 37'd45);

	// product rounding
	assign rr      = rnd30(prod_q);
	assign r33     = 33'(rr);
	assign scl_rnd = (prod_q + 66'sd32768) >>> 16;
	assign sc      = (rr > 36'sd1073741824) ? 36'sd1073741824 :
		(rr < -36'sd1073741824) ? -36'sd1073741824 : rr;

	// horner coefficient
	always_comb begin
		case (cmd.idx[1:0])
			2'd0: hc = SIN_C7;
			2'd1: hc = SIN_C5;
			2'd2: hc = SIN_C3;
			default: hc = SIN_C1;
		endcase
	end

	// matrix row decode
	assign rk  = 5'(cmd.idx - 6'd14);
	assign row = rk[4:3];
	assign sub = rk[2:0];
	assign col = (sub < 3'd3) ? sub[1:0] : 2'(sub - 3'd3);
	assign rmi = 4'({2'b0, row} * 4'd3) + {2'b0, col};
	assign vh  = vt_q[35:16];
	assign vl  = $signed({1'b0, vt_q[15:0]});

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_UPD_MUL: begin
				mul_a = 33'(scl_q[ai]);
				mul_b = 33'(vec_q[ai]);
			end
			OP_TREC: begin
				mul_a = $signed({10'd0, f_q});
				mul_b = $signed({1'b0, RECIP45});
			end
			OP_TSQ: begin
				mul_a = $signed({2'b0, t_q});
				mul_b = $signed({2'b0, t_q});
			end
			OP_HMUL: begin
				mul_a = 33'(t2_q);
				mul_b = (cmd.idx == 6'd0) ? SIN_C9 : p_q;
			end
			OP_SMUL: begin
				mul_a = $signed({2'b0, t_q});
				mul_b = p_q;
			end
			OP_MMUL: begin
				case (cmd.idx)
					6'd0: begin mul_a = 33'(trig_q[0]); mul_b = 33'(trig_q[2]); end
					6'd1: begin mul_a = 33'(trig_q[1]); mul_b = 33'(trig_q[2]); end
					6'd2: begin mul_a = 33'(trig_q[3]); mul_b = 33'(trig_q[5]); end
					6'd3: begin mul_a = 33'(trig_q[3]); mul_b = 33'(trig_q[4]); end
					6'd4: begin mul_a = 33'(trig_q[1]); mul_b = 33'(trig_q[4]); end
					6'd5: begin mul_a = 33'(sxsy_q); mul_b = 33'(trig_q[5]); end
					6'd6: begin mul_a = 33'(trig_q[1]); mul_b = 33'(trig_q[5]); end
					6'd7: begin mul_a = 33'(sxsy_q); mul_b = 33'(trig_q[4]); end
					6'd8: begin mul_a = 33'(trig_q[0]); mul_b = 33'(trig_q[3]); end
					6'd9: begin mul_a = 33'(trig_q[0]); mul_b = 33'(trig_q[4]); end
					6'd10: begin mul_a = 33'(cxsy_q); mul_b = 33'(trig_q[5]); end
					6'd11: begin mul_a = 33'(trig_q[0]); mul_b = 33'(trig_q[5]); end
					6'd12: begin mul_a = 33'(cxsy_q); mul_b = 33'(trig_q[4]); end
					6'd13: begin mul_a = 33'(trig_q[1]); mul_b = 33'(trig_q[3]); end
					default: begin
						if (sub < 3'd3) begin
							mul_a = 33'(scl_q[row]);
							mul_b = rm_q[rmi];
						end else if (sub < 3'd6) begin
							mul_a = rm_q[rmi];
							mul_b = 33'(pos_q[col]);
						end else if (sub == 3'd6) begin
							mul_a = 33'(scl_q[row]);
							mul_b = 33'(vh);
						end else begin
							mul_a = 33'(scl_q[row]);
							mul_b = 33'(vl);
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// object state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				ang_q[i] <= '0;
				scl_q[i] <= 32'sd65536;
			end
		end else begin
			unique case (cmd.op)
				OP_UPD_WB: begin
					case (func_q)
						F_SET_POS: pos_q[ai] <= vec_q[ai];
						F_SET_ANG: ang_q[ai] <= vec_q[ai];
						F_SET_SCL: scl_q[ai] <= vec_q[ai];
						F_TRANSLATE: pos_q[ai] <= sat32(66'(pos_q[ai]) + 66'(vec_q[ai]));
						F_ADD_ANG: ang_q[ai] <= sat32(66'(ang_q[ai]) + 66'(vec_q[ai]));
						F_MUL_SCL: scl_q[ai] <= sat32(scl_rnd);
						default: ;
					endcase
				end
				OP_RFIN: begin
					if (func_q == F_ADD_ANG) ang_q[ai] <= neg_q ? -rem_s : rem_s;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				func_q   <= func;
				vec_q[0] <= vec_x;
				vec_q[1] <= vec_y;
				vec_q[2] <= vec_z;
			end
			OP_RLD: begin
				neg_q <= ang_u[31];
				red_q <= ang_u[31] ? 32'd0 - ang_u : ang_u;
			end
			OP_RSTEP: begin
				if (red_q >= red_step) red_q <= red_q - red_step;
			end
			OP_RFIN: begin
				r_q <= (neg_q && rem != 25'd0) ? DEG360 - rem : rem;
			end
			OP_TQ: begin
				q_q <= tq;
				f_q <= tf;
			end
			OP_TEST: t_q <= prod_q[54:24];
			OP_TCOR: t_q <= q_q[0] ? 31'h40000000 - tc : tc;
			OP_TSQW: t2_q <= 32'(rr);
			OP_HWB: p_q <= 33'(36'(hc) + rr);
			OP_SWB: trig_q[cmd.idx[2:0]] <= 32'(q_q[1] ? -sc : sc);
			OP_MWB: begin
				case (cmd.idx)
					6'd0: sxsy_q <= 32'(rr);
					6'd1: cxsy_q <= 32'(rr);
					6'd2: begin
						rm_q[0] <= r33;
						rm_q[2] <= 33'(trig_q[2]);
					end
					6'd3: rm_q[1] <= -r33;
					6'd4: rm_q[3] <= r33;
					6'd5: rm_q[3] <= rm_q[3] + r33;
					6'd6: rm_q[4] <= r33;
					6'd7: rm_q[4] <= rm_q[4] - r33;
					6'd8: rm_q[5] <= -r33;
					6'd9: rm_q[6] <= r33;
					6'd10: rm_q[6] <= rm_q[6] - r33;
					6'd11: rm_q[7] <= r33;
					6'd12: rm_q[7] <= rm_q[7] + r33;
					6'd13: rm_q[8] <= r33;
					default: begin
						case (sub)
							3'd3: acc_q <= 64'(prod_q);
							3'd4: acc_q <= acc_q + 64'(prod_q);
							3'd5: vt_q <= rnd30(66'(acc_q) + prod_q);
							3'd6: hv_q <= prod_q;
							3'd7: m_q[{row, 2'd3}] <= sat32(hv_q + scl_rnd);
							default: m_q[{row, sub[1:0]}] <= sat32(66'(rr));
						endcase
					end
				endcase
			end
			OP_PUT: begin
				for (int k = 0; k < 12; k++) out_q[k] <= m_q[k];
			end
			default: ;
		endcase
	end

	assign m_r0_c0 = out_q[0];
	assign m_r0_c1 = out_q[1];
	assign m_r0_c2 = out_q[2];
	assign m_r0_c3 = out_q[3];
	assign m_r1_c0 = out_q[4];
	assign m_r1_c1 = out_q[5];
	assign m_r1_c2 = out_q[6];
	assign m_r1_c3 = out_q[7];
	assign m_r2_c0 = out_q[8];
	assign m_r2_c1 = out_q[9];
	assign m_r2_c2 = out_q[10];
	assign m_r2_c3 = out_q[11];

endmodule

// ===== bench/tb_object_model_matrix_builder.sv =====
module tb_object_model_matrix_builder;
	import ommb_pkg::*;

	localparam logic [2:0] F_SPARE_A = 3'd6;
	localparam logic [2:0] F_SPARE_B = 3'd7;
	localparam longint DEG360_FX = 64'sd23592960;
	localparam longint DEG90_FX  = 64'sd5898240;
	localparam longint Q30_ONE   = 64'sd1073741824;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int NUM_RANDOM    = 450;

	// matrix rows flattened, entry k at bits [k*32 +: 32]
	typedef logic [383:0] matrix_t;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rnd_shr(longint v, int k);
		return (v + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		return rnd_shr(a * b, 30);
	endfunction

	// sine of an angle already reduced into [0,360), q30 result
	function automatic longint quadrant_sine(longint r);
		longint q, f, t, t2, p, s;
		q = r / DEG90_FX;
		f = r - q * DEG90_FX;
		t = (f <<< 14) / 90;
		if (q[0])
			t = Q30_ONE - t;
		t2 = q30_mul(t, t);
		p = 64'(SIN_C9);
		p = 64'(SIN_C7) + q30_mul(t2, p);
		p = 64'(SIN_C5) + q30_mul(t2, p);
		p = 64'(SIN_C3) + q30_mul(t2, p);
		p = 64'(SIN_C1) + q30_mul(t2, p);
		s = q30_mul(t, p);
		if (s > Q30_ONE)
			s = Q30_ONE;
		if (s < -Q30_ONE)
			s = -Q30_ONE;
		return (q >= 2) ? -s : s;
	endfunction

	class matrix_scoreboard;
		longint pos[3];
		longint ang[3];
		longint scl[3];
		matrix_t pending_q[$];
		int mismatches;

		function new();
			for (int i = 0; i < 3; i++) begin
				pos[i] = 0;
				ang[i] = 0;
				scl[i] = 65536;
			end
			mismatches = 0;
		endfunction

		function void sin_cos(longint a, output longint s, output longint c);
			longint r, r2;
			r = a % DEG360_FX;
			if (r < 0)
				r += DEG360_FX;
			r2 = r + DEG90_FX;
			if (r2 >= DEG360_FX)
				r2 -= DEG360_FX;
			s = quadrant_sine(r);
			c = quadrant_sine(r2);
		endfunction

		// apply an accepted transaction to the object state and queue its matrix
		function void note_input(logic [2:0] fn, logic signed [31:0] x,
				logic signed [31:0] y, logic signed [31:0] z);
			longint v[3];
			longint a, sx, cx, sy, cy, sz, cz, sxsy, cxsy, s, acc, vt, vh, vl;
			longint r[3][3];
			matrix_t m;
			v[0] = 64'(x);
			v[1] = 64'(y);
			v[2] = 64'(z);
			for (int i = 0; i < 3; i++) begin
				case (fn)
					F_SET_POS: pos[i] = v[i];
					F_SET_ANG: ang[i] = v[i];
					F_SET_SCL: scl[i] = v[i];
					F_TRANSLATE: pos[i] = sat32(pos[i] + v[i]);
					F_ADD_ANG: begin
						a = sat32(ang[i] + v[i]);
						if (a >= DEG360_FX || a <= -DEG360_FX)
							a = a % DEG360_FX;
						ang[i] = a;
					end
					F_MUL_SCL: scl[i] = sat32(rnd_shr(scl[i] * v[i], 16));
					default: ;
				endcase
			end
			sin_cos(ang[0], sx, cx);
			sin_cos(ang[1], sy, cy);
			sin_cos(ang[2], sz, cz);
			sxsy = q30_mul(sx, sy);
			cxsy = q30_mul(cx, sy);
			r[0][0] = q30_mul(cy, cz);
			r[0][1] = -q30_mul(cy, sz);
			r[0][2] = sy;
			r[1][0] = q30_mul(cx, sz) + q30_mul(sxsy, cz);
			r[1][1] = q30_mul(cx, cz) - q30_mul(sxsy, sz);
			r[1][2] = -q30_mul(sx, cy);
			r[2][0] = q30_mul(sx, sz) - q30_mul(cxsy, cz);
			r[2][1] = q30_mul(sx, cz) + q30_mul(cxsy, sz);
			r[2][2] = q30_mul(cx, cy);
			for (int i = 0; i < 3; i++) begin
				s = scl[i];
				acc = 0;
				for (int j = 0; j < 3; j++) begin
					m[(i * 4 + j) * 32 +: 32] = 32'(sat32(rnd_shr(s * r[i][j], 30)));
					acc += r[i][j] * pos[j];
				end
				vt = rnd_shr(acc, 30);
				vh = vt >>> 16;
				vl = vt - vh * 65536;
				m[(i * 4 + 3) * 32 +: 32] = 32'(sat32(s * vh + rnd_shr(s * vl, 16)));
			end
			pending_q.push_back(m);
		endfunction

		// compare an output transaction with the oldest queued matrix
		function void check_result(matrix_t got);
			matrix_t want;
			bit bad;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output transaction %h", got);
				return;
			end
			want = pending_q.pop_front();
			bad = 0;
			for (int k = 0; k < 12; k++) begin
				if (got[k * 32 +: 32] !== want[k * 32 +: 32]) begin
					bad = 1;
					if (mismatches < 10)
						$display("m_r%0d_c%0d: expected %0d, got %0d", k / 4, k % 4,
							$signed(want[k * 32 +: 32]), $signed(got[k * 32 +: 32]));
				end
			end
			if (bad)
				mismatches++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] func = '0;
	logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] m_r0_c0, m_r0_c1, m_r0_c2, m_r0_c3;
	logic signed [31:0] m_r1_c0, m_r1_c1, m_r1_c2, m_r1_c3;
	logic signed [31:0] m_r2_c0, m_r2_c1, m_r2_c2, m_r2_c3;

	matrix_scoreboard sb = new();
	int snd_idle_pct = 33;
	int rcv_idle_pct = 80;
	int cycles = 0;

	object_model_matrix_builder dut (.*);

	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: check accepted results, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({m_r2_c3, m_r2_c2, m_r2_c1, m_r2_c0,
				m_r1_c3, m_r1_c2, m_r1_c1, m_r1_c0,
				m_r0_c3, m_r0_c2, m_r0_c1, m_r0_c0});
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// send one transaction; valid stays high after acceptance for the next one
	task automatic send(logic [2:0] fn, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1;
		func <= fn;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(fn, x, y, z);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1000, 0) << 16;
			2: return -($urandom_range(1000, 0) << 16);
			3: return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
			4: return $urandom_range(50000000, 0) - 25000000;
			default: return $urandom_range(32'h000f_ffff, 0);
		endcase
	endfunction

	task automatic random_phase(int n);
		logic [2:0] fn;
		for (int i = 0; i < n; i++) begin
			fn = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
			// scales mostly near one so products stay meaningful
			if (fn == F_MUL_SCL && $urandom_range(3) != 0)
				send(fn, $urandom_range(98304, 32768), $urandom_range(98304, 32768),
					$urandom_range(98304, 32768) - 131072);
			else
				send(fn, pick_value(), pick_value(), pick_value());
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every function, spare codes, wrap and saturation
		send(F_SPARE_A, 0, 0, 0);
		send(F_SET_POS, 32'h7fffffff, 32'h80000000, 32'h0001_0000);
		send(F_TRANSLATE, 32'h7fffffff, 32'h80000000, 32'hffff_0000);
		send(F_SET_ANG, 32'h7fffffff, 32'h80000000, 23592960);
		send(F_ADD_ANG, 32'h7fffffff, 32'h80000000, 0);
		send(F_SET_ANG, 23592959, -23592959, 5898240);
		send(F_ADD_ANG, 1, -1, 5898240);
		send(F_ADD_ANG, -1, 1, -23592960);
		send(F_SET_ANG, 11796480, 17694720, 2949120);
		send(F_SET_SCL, 32'h7fffffff, 32'h80000000, 65536);
		send(F_MUL_SCL, 32'h7fffffff, 32'h7fffffff, -65536);
		send(F_MUL_SCL, 0, 32'h80000000, 32'h80000000);
		send(F_SET_SCL, 2 << 16, -(3 << 16), 32768);
		send(F_SET_POS, 100 << 16, -(50 << 16), 12345);
		send(F_TRANSLATE, 32'h80000000, 1, -1);
		send(F_SPARE_B, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		send(F_SET_ANG, 0, 0, 0);
		send(F_ADD_ANG, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send(F_SET_SCL, 65536, 65536, 65536);

		random_phase(NUM_RANDOM / 3);
		drain();
		snd_idle_pct = 80;
		rcv_idle_pct = 33;
		random_phase(NUM_RANDOM / 3);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		random_phase(NUM_RANDOM / 3);

		drain();
		repeat (250) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
